[rtl/rigid_body_derived_data_defines.svh]
// Assertion helpers for the rigid body derived data block.
`ifndef RIGID_BODY_DERIVED_DATA_DEFINES_SVH
`define RIGID_BODY_DERIVED_DATA_DEFINES_SVH
`ifndef SYNTHESIS
`define RBDD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbdd assertion failed");
`define RBDD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rbdd assertion failed");
`else
`define RBDD_ASSERT(lbl, clk, rst_n, prop)
`define RBDD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/rbdd_pkg.sv]
`default_nettype none
package rbdd_pkg;
    localparam int RotW  = 18;
    localparam int TenW  = 20;
    localparam int WW    = 24;
    localparam int CfgW  = 60;
    localparam int PosW  = 32;

    typedef logic signed [RotW-1:0] rot_t;
    typedef logic signed [TenW-1:0] ten_t;
    typedef logic signed [WW-1:0]   winv_t;
    typedef logic signed [PosW-1:0] pos_t;
    typedef logic signed [15:0]     quat_t;

    localparam logic [1:0] CFG_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROW2 = 2'd2;

    localparam logic [1:0] ROW_LAST = 2'd2;

    // Q4.30 -> Q3.15, round half up, saturate
    function automatic rot_t rot_round(input logic signed [33:0] e);
        logic signed [34:0] s;
        logic signed [19:0] q;
        s = {e[33], e} + 35'sd16384;
        q = s[34:15];
        if (q > 20'sh1FFFF)
            return 18'sh1FFFF;
        else if (q < 20'shE0000)
            return 18'sh20000;
        else
            return q[17:0];
    endfunction

    // Q.42 -> Q12.12, round half up, saturate
    function automatic winv_t w_round(input logic signed [59:0] x);
        logic signed [60:0] s;
        logic signed [30:0] q;
        s = {x[59], x} + 61'sd536870912;
        q = s[60:30];
        if (q > 31'sh7FFFFF)
            return 24'sh7FFFFF;
        else if (q < 31'sh7F800000)
            return 24'sh800000;
        else
            return q[23:0];
    endfunction
endpackage
`default_nettype wire

[rtl/rbdd_rot.sv]
`default_nettype none
module rbdd_rot (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire rbdd_pkg::quat_t    q_r,
    input  wire rbdd_pkg::quat_t    q_i,
    input  wire rbdd_pkg::quat_t    q_j,
    input  wire rbdd_pkg::quat_t    q_k,
    output rbdd_pkg::rot_t          rot [3][3]
);
    import rbdd_pkg::*;

    logic signed [31:0] ii_reg, jj_reg, kk_reg, ij_reg, ik_reg, jk_reg;
    logic signed [31:0] ri_reg, rj_reg, rk_reg;
    rot_t               rot_reg  [3][3];
    rot_t               rot_next [3][3];

    function automatic logic signed [33:0] x34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    localparam logic signed [33:0] One = 34'sh40000000;

    always_ff @(posedge aclk) begin
        if (en) begin
            ii_reg <= q_i * q_i;
            jj_reg <= q_j * q_j;
            kk_reg <= q_k * q_k;
            ij_reg <= q_i * q_j;
            ik_reg <= q_i * q_k;
            jk_reg <= q_j * q_k;
            ri_reg <= q_r * q_i;
            rj_reg <= q_r * q_j;
            rk_reg <= q_r * q_k;
            rot_reg <= rot_next;
        end
    end

    always_comb begin
        rot_next[0][0] = rot_round(One - ((x34(jj_reg) + x34(kk_reg)) <<< 1));
        rot_next[0][1] = rot_round((x34(ij_reg) - x34(rk_reg)) <<< 1);
        rot_next[0][2] = rot_round((x34(ik_reg) + x34(rj_reg)) <<< 1);
        rot_next[1][0] = rot_round((x34(ij_reg) + x34(rk_reg)) <<< 1);
        rot_next[1][1] = rot_round(One - ((x34(ii_reg) + x34(kk_reg)) <<< 1));
        rot_next[1][2] = rot_round((x34(jk_reg) - x34(ri_reg)) <<< 1);
        rot_next[2][0] = rot_round((x34(ik_reg) - x34(rj_reg)) <<< 1);
        rot_next[2][1] = rot_round((x34(jk_reg) + x34(ri_reg)) <<< 1);
        rot_next[2][2] = rot_round(One - ((x34(ii_reg) + x34(jj_reg)) <<< 1));
    end

    assign rot = rot_reg;
endmodule
`default_nettype wire

[rtl/rigid_body_derived_data.sv]
// Rigid body derived data.
// Input channel s_*: one body pose per transfer (quaternion Q1.15, position
// Q16.16). Output channel m_*: three transfers per pose, rows 0, 1, 2, each
// with the rotation row, the translation component and the world inverse
// inertia row R*I*R^T; m_tlast marks row 2.
// Config: cfg_wr_en/cfg_addr/cfg_wr_data write tensor rows 0..2 (address 3
// ignored); write only while the block is idle.
// Pipeline: six pipeline registers plus the row output register hold each
// pose before row 0; rows 1 and 2 follow each cycle while m_tready is high.
// Throughput: set by the single result channel carrying three rows per pose;
// the pipeline takes a pose every cycle unless a pose waits in its last stage.
// Stall: when m_tready is low the output row holds; the pipeline fills and
// then drops s_tready. Nothing is lost or repeated.
// Reset (aresetn low, synchronous): valid bits and row counter clear,
// tensor registers clear to zero.
`default_nettype none
`include "rigid_body_derived_data_defines.svh"
module rigid_body_derived_data (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // quat_real, quat_i, quat_j, quat_k, pos_x, pos_y, pos_z
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row_index, rot_col0..2, translation, inertia_col0..2
    output logic [159:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [59:0]  cfg_wr_data
);
    import rbdd_pkg::*;

    logic [CfgW-1:0] ten_row_reg [3];
    logic [6:1]      vld_reg;
    logic            en, load, busy;
    logic [1:0]      cnt_reg;

    pos_t  pos_reg [6:1][3];
    rot_t  rot2 [3][3];
    rot_t  rot3_reg [3][3], rot4_reg [3][3], rot5_reg [3][3], rot6_reg [3][3];
    ten_t  ten [3][3];
    logic signed [37:0] p1_reg [3][3][3];
    logic signed [39:0] t_reg  [3][3];
    logic signed [57:0] p2_reg [3][3][3];
    winv_t w_reg [3][3];

    rot_t  h_rot_reg [3][3];
    winv_t h_w_reg   [3][3];
    pos_t  h_pos_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ten_row_reg[0] <= '0;
            ten_row_reg[1] <= '0;
            ten_row_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ROW0: ten_row_reg[0] <= cfg_wr_data;
                CFG_ROW1: ten_row_reg[1] <= cfg_wr_data;
                CFG_ROW2: ten_row_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++)
            for (int b = 0; b < 3; b++)
                ten[c][b] = ten_row_reg[c][20*b +: 20];
    end

    assign busy     = m_tvalid;
    assign load     = vld_reg[6] && (!busy || (m_tready && cnt_reg == ROW_LAST));
    assign en       = !vld_reg[6] || load;
    assign s_tready = en;

    rbdd_rot u_rot (
        .aclk (aclk),
        .en   (en),
        .q_r  (s_tdata[15:0]),
        .q_i  (s_tdata[31:16]),
        .q_j  (s_tdata[47:32]),
        .q_k  (s_tdata[63:48]),
        .rot  (rot2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[1][0] <= s_tdata[95:64];
            pos_reg[1][1] <= s_tdata[127:96];
            pos_reg[1][2] <= s_tdata[159:128];
            for (int s = 2; s <= 6; s++)
                pos_reg[s] <= pos_reg[s-1];
            rot3_reg <= rot2;
            rot4_reg <= rot3_reg;
            rot5_reg <= rot4_reg;
            rot6_reg <= rot5_reg;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++) begin
                    for (int c = 0; c < 3; c++) begin
                        p1_reg[a][b][c] <= rot2[a][c] * ten[c][b];
                        p2_reg[a][b][c] <= t_reg[a][c] * rot4_reg[b][c];
                    end
                    t_reg[a][b] <= 40'(p1_reg[a][b][0]) + 40'(p1_reg[a][b][1])
                                 + 40'(p1_reg[a][b][2]);
                    w_reg[a][b] <= w_round(60'(p2_reg[a][b][0]) + 60'(p2_reg[a][b][1])
                                 + 60'(p2_reg[a][b][2]));
                end
        end
    end

    // row output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            m_tvalid <= 1'b1;
            cnt_reg  <= '0;
        end else if (m_tvalid && m_tready) begin
            m_tvalid <= (cnt_reg != ROW_LAST);
            cnt_reg  <= (cnt_reg == ROW_LAST) ? 2'd0 : cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            h_rot_reg <= rot6_reg;
            h_w_reg   <= w_reg;
            h_pos_reg <= pos_reg[6];
        end
    end

    rot_t  o_rot [3];
    winv_t o_w   [3];
    pos_t  o_pos;

    always_comb begin
        unique case (cnt_reg)
            2'd0: begin
                o_rot = h_rot_reg[0]; o_w = h_w_reg[0]; o_pos = h_pos_reg[0];
            end
            2'd1: begin
                o_rot = h_rot_reg[1]; o_w = h_w_reg[1]; o_pos = h_pos_reg[1];
            end
            default: begin
                o_rot = h_rot_reg[2]; o_w = h_w_reg[2]; o_pos = h_pos_reg[2];
            end
        endcase
    end

    assign m_tdata = {o_w[2], o_w[1], o_w[0], o_pos, o_rot[2], o_rot[1], o_rot[0], cnt_reg};
    assign m_tlast = (cnt_reg == ROW_LAST);

    `RBDD_ASSERT(a_hold_row, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(cnt_reg))
    `RBDD_ASSERT(a_rows_continue, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    `RBDD_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `RBDD_ASSERT(a_no_drop, aclk, aresetn, vld_reg[6] && !en |=> vld_reg[6])
endmodule
`default_nettype wire
